// ----- hdl/i2crb_pkg.sv -----
package i2crb_pkg;

   localparam int DEF_NUM_REGIONS = 4;
   localparam int DEF_REGION_SIZE = 64;

   localparam int BYTE_W       = 8;
   localparam int REG_W        = 7;
   localparam int NUM_LEN_REGS = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int REQ_TDATA_W  = 16;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 16;

   localparam logic [REG_W-1:0]     OWN_ADDR_RESET      = 7'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LENGTH_0 = 3'd1;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_ACK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RPL_RELEASE = 2'd0,
      RPL_ACK     = 2'd1,
      RPL_NACK    = 2'd2
   } reply_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ADDR  = 2'd1,
      PH_WRITE = 2'd2,
      PH_READ  = 2'd3
   } phase_type;

   // where the transmitted byte comes from
   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_FF   = 2'd1,
      SRC_MEM  = 2'd2
   } src_type;

   typedef struct packed {
      reply_type reply;
      logic      send;
      src_type   src;
      logic      done;
      logic      addressed;
   } rsp_info_type;

endpackage

// ----- hdl/i2crb_ram.sv -----
module i2crb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/i2crb_ctrl.sv -----
module i2crb_ctrl #(
   parameter int NUM_REGIONS = i2crb_pkg::DEF_NUM_REGIONS,
   parameter int REGION_SIZE = i2crb_pkg::DEF_REGION_SIZE
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [i2crb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [i2crb_pkg::REG_W-1:0]             csr_wdata,
   input  logic                                    acc,
   input  logic [1:0]                              op,
   input  logic [i2crb_pkg::BYTE_W-1:0]            bus_byte,
   input  logic                                    master_nack,
   output logic                                    ram_we,
   output logic                                    ram_re,
   output logic [(NUM_REGIONS * REGION_SIZE > 1 ?
                  $clog2(NUM_REGIONS * REGION_SIZE) : 1)-1:0] ram_addr,
   output logic [i2crb_pkg::BYTE_W-1:0]            ram_wdata,
   output i2crb_pkg::rsp_info_type                 info
);
   import i2crb_pkg::*;

   localparam int DEPTH  = NUM_REGIONS * REGION_SIZE;
   localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = NUM_REGIONS > 1 ? $clog2(NUM_REGIONS) : 1;
   localparam int PTR_W  = $clog2(REGION_SIZE + 1);
   localparam int LEN_W  = 9;

   logic [REG_W-1:0] own_ff;
   logic [REG_W-1:0] len_ff [NUM_LEN_REGS];

   phase_type        phase_ff, phase_in;
   logic             rv_ff, rv_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] fill_ff [NUM_REGIONS];
   logic [PTR_W-1:0] fill_in [NUM_REGIONS];

   op_type           op_c;
   logic             addr_match;
   logic [IDX_W-1:0] sel_idx;
   logic [PTR_W-1:0] cur_len;
   logic [PTR_W-1:0] sel_len;
   logic [PTR_W-1:0] ptr_inc;
   logic             do_fetch;

   // effective length: capped at the region size, zero past the registers
   function automatic logic [PTR_W-1:0] eff_len(input logic [IDX_W-1:0] idx,
                                                input logic [REG_W-1:0] lens [NUM_LEN_REGS]);
      logic [LEN_W-1:0] l;
      l = '0;
      for (int k = 0; k < NUM_LEN_REGS; k++) begin
         if (k < NUM_REGIONS && idx == IDX_W'(k)) begin
            l = LEN_W'(lens[k]);
         end
      end
      if (l > LEN_W'(REGION_SIZE)) begin
         l = LEN_W'(REGION_SIZE);
      end
      return PTR_W'(l);
   endfunction

   assign op_c       = op_type'(op);
   assign addr_match = (bus_byte == '0) || (bus_byte[BYTE_W-1:1] == own_ff);
   assign sel_idx    = IDX_W'(bus_byte);
   assign cur_len    = eff_len(idx_ff, len_ff);
   assign sel_len    = eff_len(sel_idx, len_ff);
   assign ptr_inc    = ptr_ff + PTR_W'(1);
   assign ram_addr   = ADDR_W'(ADDR_W'(idx_ff) * ADDR_W'(REGION_SIZE)) + ADDR_W'(ptr_ff);
   assign ram_wdata  = bus_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= OWN_ADDR_RESET;
         for (int k = 0; k < NUM_LEN_REGS; k++) begin
            len_ff[k] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_OWN_ADDRESS) begin
            own_ff <= csr_wdata;
         end
         for (int k = 0; k < NUM_LEN_REGS; k++) begin
            if (csr_index == CSR_IDX_W'(CSR_REGION_LENGTH_0 + CSR_IDX_W'(k))) begin
               len_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         case (op_c)
            OP_START: phase_in = PH_ADDR;
            OP_BYTE: begin
               if (phase_ff == PH_ADDR) begin
                  if (!addr_match) begin
                     phase_in = PH_IDLE;
                  end else if (bus_byte[0]) begin
                     phase_in = PH_READ;
                  end else begin
                     phase_in = PH_WRITE;
                  end
               end
            end
            OP_ACK: begin
               if (phase_ff == PH_READ && master_nack) begin
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   // reply, pointer, buffer access
   always_comb begin
      info.reply     = RPL_RELEASE;
      info.send      = 1'b0;
      info.src       = SRC_ZERO;
      info.done      = 1'b0;
      info.addressed = (phase_in == PH_WRITE) || (phase_in == PH_READ);
      rv_in          = rv_ff;
      idx_in         = idx_ff;
      ptr_in         = ptr_ff;
      fill_in        = fill_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      do_fetch       = 1'b0;
      if (acc) begin
         case (op_c)
            OP_BYTE: begin
               case (phase_ff)
                  PH_ADDR: begin
                     if (addr_match) begin
                        info.reply = RPL_ACK;
                        if (bus_byte[0]) begin
                           do_fetch = 1'b1;
                        end else begin
                           rv_in = 1'b0;
                        end
                     end
                  end
                  PH_WRITE: begin
                     if (!rv_ff) begin
                        if ({1'b0, bus_byte} < (BYTE_W + 1)'(NUM_REGIONS)) begin
                           rv_in  = 1'b1;
                           idx_in = sel_idx;
                           ptr_in = '0;
                           if (sel_len == '0) begin
                              info.reply = RPL_NACK;
                              info.done  = 1'b1;
                           end else begin
                              info.reply = RPL_ACK;
                           end
                        end else begin
                           info.reply = RPL_NACK;
                        end
                     end else if (ptr_ff < cur_len) begin
                        ram_we = 1'b1;
                        ptr_in = ptr_inc;
                        if (ptr_inc > fill_ff[idx_ff]) begin
                           fill_in[idx_ff] = ptr_inc;
                        end
                        if (ptr_inc == cur_len) begin
                           info.reply = RPL_NACK;
                           info.done  = 1'b1;
                        end else begin
                           info.reply = RPL_ACK;
                        end
                     end else begin
                        info.reply = RPL_NACK;
                     end
                  end
                  default: ;
               endcase
            end
            OP_ACK: begin
               if (phase_ff == PH_READ && !master_nack) begin
                  do_fetch = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (do_fetch) begin
         info.send = 1'b1;
         if (!rv_ff) begin
            info.src = SRC_ZERO;
         end else if (ptr_ff >= cur_len) begin
            info.src = SRC_FF;
         end else begin
            // bytes beyond the fill count were never written and read as zero
            if (ptr_ff < fill_ff[idx_ff]) begin
               info.src = SRC_MEM;
               ram_re   = 1'b1;
            end
            ptr_in    = ptr_inc;
            info.done = (ptr_inc == cur_len);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rv_ff    <= 1'b0;
         idx_ff   <= '0;
         ptr_ff   <= '0;
         for (int k = 0; k < NUM_REGIONS; k++) begin
            fill_ff[k] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         rv_ff    <= rv_in;
         idx_ff   <= idx_in;
         ptr_ff   <= ptr_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

// ----- hdl/i2crb_resp.sv -----
module i2crb_resp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                acc,
   input  i2crb_pkg::rsp_info_type             info,
   input  logic [i2crb_pkg::BYTE_W-1:0]        ram_rdata,
   output logic                                take_ok,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [i2crb_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import i2crb_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   rsp_info_type           s1_info_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic                   s1_move;
   logic [BYTE_W-1:0]      send_byte;

   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign take_ok = !s1_valid_ff || s1_move;

   always_comb begin
      case (s1_info_ff.src)
         SRC_MEM: send_byte = ram_rdata;
         SRC_FF:  send_byte = 8'hFF;
         default: send_byte = '0;
      endcase
   end

   assign s1_valid_in  = acc || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_info_ff <= info;
      end
      if (s1_move) begin
         out_data_ff <= {3'b000, s1_info_ff.addressed, s1_info_ff.done, send_byte,
                         s1_info_ff.send, s1_info_ff.reply};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- hdl/i2c_slave_register_buffer_core.sv -----
// Byte-level I2C slave register buffer. Each request is one bus event (start, master byte,
// or master acknowledge bit) and yields exactly one response telling how to drive the bus
// and which byte to shift out. Requests are taken one per clock while the response path
// is not stalled by rsp_tready; a response passes through the buffer RAM's registered read
// and then the output register, and the output register lets the next request enter while a
// response waits. Buffer contents live in one RAM of NUM_REGIONS * REGION_SIZE bytes; a
// per-region fill count makes unwritten bytes read as zero, so there is no clearing pass
// after reset and the block is ready in the first cycle out of reset.
module i2c_slave_register_buffer_core #(
   parameter int NUM_REGIONS = i2crb_pkg::DEF_NUM_REGIONS,
   parameter int REGION_SIZE = i2crb_pkg::DEF_REGION_SIZE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [i2crb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [i2crb_pkg::REG_W-1:0]          csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] bus_byte, [8] master_nack, [15:9] zero
   input  logic [i2crb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  logic [i2crb_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] reply, [2] send_valid, [10:3] send_byte, [11] transfer_complete,
   // [12] addressed, [15:13] zero
   output logic [i2crb_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import i2crb_pkg::*;

   localparam int DEPTH  = NUM_REGIONS * REGION_SIZE;
   localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

   logic              acc;
   logic              take_ok;
   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;
   rsp_info_type      info;

   assign req_tready = take_ok;
   assign acc        = req_tvalid && take_ok;

   i2crb_ctrl #(
      .NUM_REGIONS(NUM_REGIONS),
      .REGION_SIZE(REGION_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .acc        (acc),
      .op         (req_tuser),
      .bus_byte   (req_tdata[BYTE_W-1:0]),
      .master_nack(req_tdata[BYTE_W]),
      .ram_we     (ram_we),
      .ram_re     (ram_re),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .info       (info)
   );

   i2crb_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_addr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_addr),
      .rdata(ram_rdata)
   );

   i2crb_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .info      (info),
      .ram_rdata (ram_rdata),
      .take_ok   (take_ok),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- hdl/i2crb_checker.sv -----
module i2crb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [i2crb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import i2crb_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[10:3] == 8'h00)
      else $error("send_byte nonzero without send_valid");

   a_reply_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("undefined reply code");

   // completion comes only with a final write NACK or with a byte sent
   a_done_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> (rsp_tdata[1:0] == RPL_NACK) || rsp_tdata[2])
      else $error("completion pulse out of context");

endmodule

bind i2c_slave_register_buffer_core i2crb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
